FILE: hdl/audio_peak_normalized_trigger_assert.svh
// Assertion macros used by the checker file.
`ifndef AUDIO_PEAK_NORMALIZED_TRIGGER_ASSERT_SVH
`define AUDIO_PEAK_NORMALIZED_TRIGGER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define APNT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define APNT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/apnt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package apnt_pkg;

	// Q1.15 levels: 0.65 and 0.1
	localparam logic [15:0] LEVEL_HIGH = 16'd21299;
	localparam logic [15:0] LEVEL_LOW  = 16'd3277;

	// sample * LEVEL_HIGH stays below 2^30 whenever a divide is needed
	localparam int DIVIDEND_W = 30;
	localparam int DIV_STEPS  = DIVIDEND_W;

	// register indexes on the configuration port
	localparam logic [1:0] REG_ENABLE    = 2'd0;
	localparam logic [1:0] REG_DYNAMIC   = 2'd1;
	localparam logic [1:0] REG_SENSITIVE = 2'd2;
	localparam logic [1:0] REG_STATIC    = 2'd3;

	// data handed from one window cell to the next
	typedef struct packed {
		logic        valid;
		logic [15:0] value;
		logic [15:0] peak;
	} cell_link_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

FILE: hdl/apnt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module apnt_cell
	import apnt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       shift,
	input  wire cell_link_t link_in,
	output cell_link_t      link_out
);

	logic        valid_q;
	logic [15:0] entry_q;
	logic [15:0] peak_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= link_in.valid;
		end
	end

	// running max moves one cell per cycle; an empty cell passes it through
	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= link_in.value;
		end
		peak_q <= (valid_q && (entry_q > link_in.peak)) ? entry_q : link_in.peak;
	end

	assign link_out.valid = valid_q;
	assign link_out.value = entry_q;
	assign link_out.peak  = peak_q;

endmodule

`default_nettype wire

FILE: hdl/apnt_div.sv
`timescale 1ns / 1ps
`default_nettype none

module apnt_div
	import apnt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [15:0]           divisor,
	output logic      [15:0]           quotient,
	output div_stat_t                  stat
);

	localparam int CNT_W = $clog2(DIV_STEPS);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] dq_q;
	logic [15:0]           rem_q;
	logic [15:0]           div_q;
	logic [16:0]           trial;
	logic                  ge;

	// one restoring step per cycle, quotient bits shift in behind the dividend
	assign trial = {rem_q, dq_q[DIVIDEND_W-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DIVIDEND_W-2:0], ge};
			rem_q <= ge ? 16'(trial - {1'b0, div_q}) : trial[15:0];
		end
	end

	// quotient never exceeds LEVEL_HIGH since sample <= peak
	assign quotient  = dq_q[15:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

FILE: hdl/audio_peak_normalized_trigger.sv
// Flow: when disabled or in static mode an accepted item goes straight to the done state;
// in dynamic mode it passes the walk, peak, compare and done states, and the divider when scaled:
// the running peak walks the cell chain one cell per cycle, then a 30-step serial divider.
// Throughput: one item at a time; in_ready returns as the result is registered.
// Reset (arst_n low) clears config, state, window valid bits and out_valid.
`timescale 1ns / 1ps
`default_nettype none

module audio_peak_normalized_trigger
	import apnt_pkg::*;
#(
	parameter int WINDOW_DEPTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] sample,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             trigger,
	output logic      [15:0] window_peak
);

	localparam int CNT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_PEAK,
		S_DIV,
		S_CMP,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             enable_q;
	logic             dynamic_q;
	logic [15:0]      sens_q;
	logic [15:0]      thresh_q;
	logic [15:0]      sample_q;
	logic [15:0]      scaled_q;
	logic [15:0]      peak_q;
	logic             res_trig_q;
	logic             out_valid_q;
	logic             out_trig_q;
	logic [15:0]      out_peak_q;

	cell_link_t       link [WINDOW_DEPTH+1];
	logic             shift;
	logic             in_range;
	logic             div_start;
	logic [31:0]      product;
	logic [15:0]      quotient;
	div_stat_t        div_stat;
	logic signed [17:0] level;
	logic             cmp_hit;
	logic             res_load;

	assign in_ready = (state_q == S_IDLE);
	assign shift    = (state_q == S_PEAK);
	assign res_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	assign link[0].valid = 1'b1;
	assign link[0].value = sample_q;
	assign link[0].peak  = sample_q;

	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		apnt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (shift),
			.link_in  (link[i]),
			.link_out (link[i+1])
		);
	end

	assign in_range  = (sample_q > LEVEL_LOW) && (sample_q < LEVEL_HIGH);
	assign div_start = shift && in_range;
	assign product   = {16'd0, sample_q} * {16'd0, LEVEL_HIGH};

	apnt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product[DIVIDEND_W-1:0]),
		.divisor  (link[WINDOW_DEPTH].peak),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// level may go negative, then every sample fires
	assign level   = $signed({2'b00, LEVEL_HIGH}) - $signed({2'b00, sens_q});
	assign cmp_hit = $signed({2'b00, scaled_q}) >= level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			dynamic_q <= 1'b0;
			sens_q    <= '0;
			thresh_q  <= LEVEL_HIGH;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE:    enable_q  <= cfg_data[0];
				REG_DYNAMIC:   dynamic_q <= cfg_data[0];
				REG_SENSITIVE: sens_q    <= cfg_data;
				REG_STATIC:    thresh_q  <= cfg_data;
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			sample_q    <= '0;
			scaled_q    <= '0;
			peak_q      <= '0;
			res_trig_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_trig_q  <= 1'b0;
			out_peak_q  <= '0;
		end else begin
			// load a finished item, or drop the one just taken
			if (res_load) begin
				out_valid_q <= 1'b1;
				out_trig_q  <= res_trig_q;
				out_peak_q  <= peak_q;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						sample_q   <= sample;
						peak_q     <= '0;
						res_trig_q <= enable_q && !dynamic_q && (sample >= thresh_q);
						cnt_q      <= '0;
						state_q    <= (enable_q && dynamic_q) ? S_WALK : S_DONE;
					end
				end
				S_WALK: begin
					// hold until the running max has left the last cell
					if (cnt_q == CNT_W'(WINDOW_DEPTH - 1)) begin
						state_q <= S_PEAK;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				S_PEAK: begin
					peak_q   <= link[WINDOW_DEPTH].peak;
					scaled_q <= sample_q;
					state_q  <= in_range ? S_DIV : S_CMP;
				end
				S_DIV: begin
					if (div_stat.done) begin
						scaled_q <= quotient;
						state_q  <= S_CMP;
					end
				end
				S_CMP: begin
					res_trig_q <= cmp_hit;
					state_q    <= S_DONE;
				end
				S_DONE: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign trigger     = out_trig_q;
	assign window_peak = out_peak_q;

endmodule

`default_nettype wire

FILE: hdl/apnt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "audio_peak_normalized_trigger_assert.svh"

module apnt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        trigger,
	input wire logic [15:0] window_peak
);

	`APNT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(trigger) && $stable(window_peak), "result changed while stalled")
	`APNT_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "item taken while another is in work")
	`APNT_ASSERT_NOW(a_ready_on_result, $rose(out_valid), in_ready, "result registered without freeing input")
	`APNT_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready && !out_valid, !out_valid, "result appeared in the cycle after accept")

endmodule

bind audio_peak_normalized_trigger apnt_checker u_apnt_checker (.*);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import apnt_pkg::*;

	localparam int WIN         = 32;
	localparam int DRAIN_WAIT  = WIN + 60;
	localparam int LONG_HOLD   = 400;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 128;

	typedef struct packed {
		logic        trig;
		logic [15:0] peak;
	} trig_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] sample = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        trigger;
	logic [15:0] window_peak;

	// predictor state and register copies
	logic [15:0] win_mem [WIN];
	int unsigned win_fill;
	int unsigned win_ptr;
	logic        m_enable;
	logic        m_dynamic;
	logic [15:0] m_sens;
	logic [15:0] m_static;

	logic [15:0]  pend_samples [$];
	trig_result_t expected_trig [$];

	int  err_cnt;
	int  sent_cnt;
	int  checked_cnt;
	int  fired_cnt;
	int  dyn_cnt;
	int  cyc;
	bit  src_calm;
	bit  sink_calm;
	int  src_gap;
	int  snk_gap;
	int  hold_left;
	int  stall_asks;
	int  stall_seen;

	audio_peak_normalized_trigger #(
		.WINDOW_DEPTH(WIN)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.trigger    (trigger),
		.window_peak(window_peak)
	);

	always #5 clk = ~clk;

	// Compute the result for one sample and, in dynamic mode, advance the window.
	function automatic trig_result_t predict_trigger(input logic [15:0] s);
		trig_result_t r;
		logic [31:0]  pk;
		logic [31:0]  scaled;
		logic [31:0]  s32;
		int           lvl;
		r = '0;
		s32 = {16'd0, s};
		if (m_enable) begin
			if (m_dynamic) begin
				dyn_cnt++;
				pk = s32;
				for (int i = 0; i < win_fill; i++) begin
					if (win_mem[i] > pk)
						pk = {16'd0, win_mem[i]};
				end
				scaled = s32;
				if (s > LEVEL_LOW && s < LEVEL_HIGH)
					scaled = (s32 * 32'(LEVEL_HIGH)) / pk;
				lvl = int'(LEVEL_HIGH) - int'(m_sens);
				r.trig = (int'(scaled) >= lvl);
				r.peak = pk[15:0];
				win_mem[win_ptr] = s;
				win_ptr = (win_ptr + 1) % WIN;
				if (win_fill < WIN)
					win_fill++;
			end else begin
				r.trig = (s >= m_static);
			end
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] pick_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 16'($urandom);
		else if (r < 22) begin
			case ($urandom_range(0, 8))
				0: return 16'd0;
				1: return LEVEL_LOW;
				2: return LEVEL_LOW + 16'd1;
				3: return LEVEL_HIGH - 16'd1;
				4: return LEVEL_HIGH;
				5: return LEVEL_HIGH + 16'd1;
				6: return 16'd32767;
				7: return 16'd32768;
				default: return 16'hFFFF;
			endcase
		end else if (r < 65)
			return 16'($urandom_range(LEVEL_LOW + 1, LEVEL_HIGH - 1));
		else
			return 16'($urandom_range(0, 32768));
	endfunction

	// Drive one register; the block is idle whenever this is called.
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_ENABLE:    m_enable = data[0];
			REG_DYNAMIC:   m_dynamic = data[0];
			REG_SENSITIVE: m_sens = data;
			REG_STATIC:    m_static = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// check away from the rising edge so the sender's updates have settled
	task automatic drain();
		while (pend_samples.size() != 0 || in_valid || expected_trig.size() != 0)
			@(negedge clk);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin : drive
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample <= '0;
			src_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_trig.push_back(predict_trigger(sample));
				sent_cnt++;
				src_gap = src_calm ? 0 : pick_gap();
			end
			if (in_valid && !in_ready) begin
				// hold the item until taken
			end else if (src_gap > 0) begin
				src_gap--;
				in_valid <= 1'b0;
			end else if (pend_samples.size() != 0) begin
				sample <= pend_samples.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin : observe
		trig_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			snk_gap = 0;
			hold_left = 0;
			stall_seen = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_trig.size() == 0) begin
					$error("result with nothing expected: trigger %0d window_peak %0d",
						trigger, window_peak);
					err_cnt++;
				end else begin
					want = expected_trig.pop_front();
					checked_cnt++;
					if (want.trig)
						fired_cnt++;
					if (trigger !== want.trig) begin
						$error("trigger: expected %0d, got %0d", want.trig, trigger);
						err_cnt++;
					end
					if (window_peak !== want.peak) begin
						$error("window_peak: expected %0d, got %0d", want.peak, window_peak);
						err_cnt++;
					end
				end
				snk_gap = sink_calm ? 0 : pick_gap();
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_asks != stall_seen) begin
				stall_seen++;
				hold_left = LONG_HOLD;
				out_ready <= 1'b0;
			end else if (snk_gap > 0) begin
				snk_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc > CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin : stim
		logic [15:0] sens_pick [5];
		logic [15:0] thr_pick [5];
		logic        en;
		logic        dyn;
		logic [15:0] sens;
		logic [15:0] thr;
		sens_pick = '{16'd0, 16'd32768, 16'hFFFF, 16'd21299, 16'd1};
		thr_pick = '{16'd0, 16'd32768, 16'hFFFF, 16'd21299, 16'd1};
		m_enable = 1'b0;
		m_dynamic = 1'b0;
		m_sens = '0;
		m_static = LEVEL_HIGH;
		win_fill = 0;
		win_ptr = 0;
		err_cnt = 0;
		sent_cnt = 0;
		checked_cnt = 0;
		fired_cnt = 0;
		dyn_cnt = 0;
		cyc = 0;
		stall_asks = 0;
		src_calm = 1'b0;
		sink_calm = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// disabled after reset: window untouched, no trigger
		pend_samples = '{16'd0, 16'hFFFF, LEVEL_HIGH, LEVEL_LOW + 16'd1};
		drain();

		// dynamic from an empty window: zero peak first, then band edges
		write_reg(REG_ENABLE, 16'h0001);
		write_reg(REG_DYNAMIC, 16'h0001);
		write_reg(REG_SENSITIVE, 16'd0);
		pend_samples = '{16'd0, LEVEL_LOW + 16'd1, LEVEL_HIGH - 16'd1, LEVEL_LOW,
			LEVEL_HIGH, 16'd12000, 16'd32768, 16'hFFFF, 16'd4000, 16'h5555};
		drain();

		// level below zero: everything fires
		write_reg(REG_SENSITIVE, 16'hFFFF);
		pend_samples = '{16'd3500, 16'd0};
		drain();

		// static compare at the threshold extremes
		write_reg(REG_DYNAMIC, 16'h0000);
		write_reg(REG_STATIC, 16'd0);
		pend_samples = '{16'd0, 16'd1};
		drain();
		write_reg(REG_STATIC, 16'hFFFF);
		pend_samples = '{16'hFFFE, 16'hFFFF};
		drain();
		write_reg(REG_STATIC, 16'd32768);
		pend_samples = '{16'd32767, 16'd32768};
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			en = (ph % 6 == 5) ? 1'b0 : 1'b1;
			dyn = (ph % 3 != 2);
			sens = (ph < 5) ? sens_pick[ph] : 16'($urandom_range(0, 12000));
			thr = (ph < 5) ? thr_pick[(ph + 2) % 5] : 16'($urandom_range(0, 32768));
			if (ph == 9)
				sens = 16'($urandom);
			// upper bits of the one-bit registers are ignored
			write_reg(REG_ENABLE, {15'($urandom), en});
			write_reg(REG_DYNAMIC, {15'($urandom), dyn});
			write_reg(REG_SENSITIVE, sens);
			write_reg(REG_STATIC, thr);
			src_calm = (ph % 4 == 1);
			sink_calm = (ph % 4 == 2);
			if (ph == 3)
				stall_asks <= stall_asks + 1;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// a loud sample now and then, the rest from pick_sample
				if ($urandom_range(0, 19) == 0)
					pend_samples.push_back(16'($urandom_range(21299, 32768)));
				else
					pend_samples.push_back(pick_sample());
			end
			drain();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (expected_trig.size() != 0) begin
			$error("%0d results never arrived", expected_trig.size());
			err_cnt++;
		end
		$display("run covered %0d samples (%0d dynamic), %0d results checked, %0d fired",
			sent_cnt, dyn_cnt, checked_cnt, fired_cnt);
		if (err_cnt == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
